// ----- rtl/core/bsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Bank switch mapper package
// Types, codes and constants shared by the mapper, its PRG RAM and its channels.
// ----------------------------------------------------------------------------
package bsm_pkg;

  // Bus event kinds carried by a request.
  typedef enum logic [2:0] {
    OP_CPU_WRITE = 3'd0,
    OP_CPU_READ  = 3'd1,
    OP_PPU_WRITE = 3'd2,
    OP_PPU_READ  = 3'd3,
    OP_A12_RISE  = 3'd4
  } opcode_e;

  // Where an access lands.
  typedef enum logic [2:0] {
    TGT_NONE      = 3'd0,
    TGT_PRG_RAM   = 3'd1,
    TGT_PRG_ROM   = 3'd2,
    TGT_CHR_ROM   = 3'd3,
    TGT_NAMETABLE = 3'd4
  } target_e;

  typedef enum logic [1:0] {
    MIRROR_VERT  = 2'd0,
    MIRROR_HORIZ = 2'd1,
    MIRROR_FOUR  = 2'd2
  } mirror_e;

  // Register windows selected by CPU address bits 14:13 above 0x8000.
  localparam logic [1:0] REG_BANK      = 2'b00;
  localparam logic [1:0] REG_MIRROR    = 2'b01;
  localparam logic [1:0] REG_IRQ_LATCH = 2'b10;
  localparam logic [1:0] REG_IRQ_EN    = 2'b11;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 6;
  localparam logic [CfgIdxW-1:0] CFG_PRG_BANKS   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_FOUR_SCREEN = 1'b1;
  localparam logic [CfgDataW-1:0] PRG_BANKS_RESET = 6'd32;

  // PRG RAM window starts at 0x6000: CPU address bits 15:13.
  localparam logic [2:0] PRG_RAM_WINDOW = 3'b011;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [18:0] mapped_address;
    logic [7:0]  read_data;
    logic        irq_request;
    logic [1:0]  mirror_mode;
  } rsp_t;

  // Access strobe towards the PRG RAM.
  typedef struct packed {
    logic       en;
    logic       we;
    logic [7:0] wdata;
  } ram_ctrl_t;

endpackage

// ----- rtl/core/bsm_stream_if.sv -----
// ----------------------------------------------------------------------------
// Bank switch mapper stream channel
// Valid/ready channel carrying one payload; a request moves when both are high.
// ----------------------------------------------------------------------------
interface bsm_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/core/bank_switch_mapper_irq_counter_unit.sv -----
// ----------------------------------------------------------------------------
// Bank switch mapper with scanline IRQ counter
// Maps CPU and PPU bus events onto PRG/CHR ROM offsets, PRG RAM and nametables,
// and steps the scanline counter on each PPU A12 rise event.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  req_i     in         valid / ready          opcode, address, write_data
//  rsp_o     out        valid / ready          target, mapped_address, read_data,
//                                              irq_request, mirror_mode
//  cfg       in         cfg_we_i (no wait)     cfg_index_i, cfg_wdata_i
//
//  One request is taken per cycle while req_i.ready is high; its response is
//  registered. The PRG RAM port is read and written at the request edge and its
//  registered read data meets the response in the output register.
//  After reset the PRG RAM is zeroed, one byte a cycle, over PRG_RAM_DEPTH entries;
//  req_i.ready stays low during that pass while configuration writes still land.
//  A two-entry output stage (output register plus skid register) keeps taking
//  requests while a response waits; ready also drops once both entries are full.
//
module bank_switch_mapper_irq_counter_unit #(
  parameter int unsigned PRG_RAM_DEPTH = 8192
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bsm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bsm_pkg::CfgDataW-1:0]   cfg_wdata_i,
  bsm_stream_if.sink                     req_i,
  bsm_stream_if.source                   rsp_o
);
  import bsm_pkg::*;

  localparam int unsigned AW = $clog2(PRG_RAM_DEPTH);
  // Wrap constants for the RAM index; the window offset is below 0x2000, which is
  // below four times any depth above 0x800, and two conditional subtractions suffice.
  localparam logic [13:0] Depth1 = 14'(PRG_RAM_DEPTH);
  localparam logic [13:0] Depth2 = 14'(2 * PRG_RAM_DEPTH);

  // Configuration.
  logic [5:0] prg_banks_q;
  logic       four_screen_q;

  // Mapper state.
  logic [7:0] bank_q [8];
  logic [7:0] bank_d [8];
  logic [2:0] bank_sel_q, bank_sel_d;
  logic       prg_swap_q, prg_swap_d;
  logic       chr_inv_q, chr_inv_d;
  logic [1:0] mirror_q, mirror_d;
  logic [7:0] irq_latch_q, irq_latch_d;
  logic [7:0] irq_count_q, irq_count_d;
  logic       irq_off_q, irq_off_d;

  // Output register and skid register.
  rsp_t out_q, skid_q;
  rsp_t out_fill, skid_fill;
  logic out_v_q, skid_v_q;
  logic out_pend_q, skid_pend_q;

  // Request-side decode.
  req_t       req;
  rsp_t       rsp_new;
  logic       rsp_is_read;
  ram_ctrl_t  ram_ctrl;
  logic [AW-1:0] ram_addr;
  logic [7:0] ram_rdata;
  logic       ram_busy;
  logic       in_fire;
  logic       rsp_fire;
  logic [4:0] last_pair;

  assign req      = req_i.payload;
  assign in_fire  = req_i.valid && req_i.ready;
  assign rsp_fire = out_v_q && rsp_o.ready;
  assign req_i.ready = !skid_v_q && !ram_busy;

  // The fixed PRG banks sit at (N-1)*16 KiB, reduced to the 19-bit address space.
  assign last_pair = 5'(prg_banks_q - 6'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_banks_q   <= PRG_BANKS_RESET;
      four_screen_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PRG_BANKS:   prg_banks_q   <= cfg_wdata_i;
        CFG_FOUR_SCREEN: four_screen_q <= cfg_wdata_i[0];
      endcase
    end
  end

  // Decode of one request: the response fields and the state it leaves.
  always_comb begin
    logic [13:0] ofs;
    logic [5:0]  prg_bank;
    logic [12:0] chr_t;
    logic [2:0]  chr_idx;
    logic [7:0]  count_next;

    bank_d      = bank_q;
    bank_sel_d  = bank_sel_q;
    prg_swap_d  = prg_swap_q;
    chr_inv_d   = chr_inv_q;
    mirror_d    = mirror_q;
    irq_latch_d = irq_latch_q;
    irq_count_d = irq_count_q;
    irq_off_d   = irq_off_q;
    rsp_new     = '0;
    rsp_is_read = 1'b0;
    ram_ctrl    = '0;

    ofs = {1'b0, req.address[12:0]};
    if (ofs >= Depth2) begin
      ofs = ofs - Depth2;
    end
    if (ofs >= Depth1) begin
      ofs = ofs - Depth1;
    end
    ram_addr = AW'(ofs);

    unique case (req.address[14:13])
      2'b00:   prg_bank = prg_swap_q ? {last_pair, 1'b0} : bank_q[6][5:0];
      2'b01:   prg_bank = bank_q[7][5:0];
      2'b10:   prg_bank = prg_swap_q ? bank_q[6][5:0] : {last_pair, 1'b0};
      default: prg_bank = {last_pair, 1'b1};
    endcase

    // CHR inversion swaps the two pattern table halves.
    chr_t   = {req.address[12] ^ chr_inv_q, req.address[11:0]};
    chr_idx = 3'd2 + {1'b0, chr_t[11:10]};

    count_next = (irq_count_q == 8'd0) ? irq_latch_q : irq_count_q - 8'd1;

    unique case (req.opcode)
      OP_CPU_WRITE, OP_CPU_READ: begin
        if (req.address[15:13] == PRG_RAM_WINDOW) begin
          rsp_new.target         = TGT_PRG_RAM;
          rsp_new.mapped_address = 19'(ram_addr);
          ram_ctrl.en            = 1'b1;
          ram_ctrl.we            = (req.opcode == OP_CPU_WRITE);
          ram_ctrl.wdata         = req.write_data;
          rsp_is_read            = (req.opcode == OP_CPU_READ);
        end else if (req.address[15]) begin
          if (req.opcode == OP_CPU_READ) begin
            rsp_new.target         = TGT_PRG_ROM;
            rsp_new.mapped_address = {prg_bank, req.address[12:0]};
          end else begin
            unique case (req.address[14:13])
              REG_BANK: begin
                if (req.address[0]) begin
                  bank_d[bank_sel_q] = req.write_data;
                end else begin
                  bank_sel_d = req.write_data[2:0];
                  prg_swap_d = req.write_data[6];
                  chr_inv_d  = req.write_data[7];
                end
              end
              REG_MIRROR: begin
                if (!req.address[0]) begin
                  mirror_d = four_screen_q ? MIRROR_FOUR : {1'b0, req.write_data[0]};
                end
              end
              REG_IRQ_LATCH: begin
                if (req.address[0]) begin
                  irq_count_d = 8'd0;
                end else begin
                  irq_latch_d = req.write_data;
                end
              end
              REG_IRQ_EN: irq_off_d = !req.address[0];
            endcase
          end
        end
      end
      OP_PPU_WRITE, OP_PPU_READ: begin
        if (!req.address[13]) begin
          rsp_new.target = TGT_CHR_ROM;
          if (!chr_t[12]) begin
            rsp_new.mapped_address = chr_t[11]
                ? {1'b0, bank_q[1][7:1], chr_t[10:0]}
                : {1'b0, bank_q[0][7:1], chr_t[10:0]};
          end else begin
            rsp_new.mapped_address = {1'b0, bank_q[chr_idx], chr_t[9:0]};
          end
        end else begin
          rsp_new.target         = TGT_NAMETABLE;
          rsp_new.mapped_address = {5'd0, req.address[13:0]};
        end
      end
      OP_A12_RISE: begin
        irq_count_d         = count_next;
        rsp_new.irq_request = (count_next == 8'd0) && !irq_off_q;
      end
      default: begin
      end
    endcase

    rsp_new.mirror_mode = four_screen_q ? MIRROR_FOUR : mirror_d;

    if (!in_fire) begin
      ram_ctrl.en = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        bank_q[i] <= '0;
      end
      bank_sel_q  <= '0;
      prg_swap_q  <= 1'b0;
      chr_inv_q   <= 1'b0;
      mirror_q    <= MIRROR_VERT;
      irq_latch_q <= '0;
      irq_count_q <= '0;
      irq_off_q   <= 1'b1;
    end else if (in_fire) begin
      bank_q      <= bank_d;
      bank_sel_q  <= bank_sel_d;
      prg_swap_q  <= prg_swap_d;
      chr_inv_q   <= chr_inv_d;
      mirror_q    <= mirror_d;
      irq_latch_q <= irq_latch_d;
      irq_count_q <= irq_count_d;
      irq_off_q   <= irq_off_d;
    end
  end

  bsm_prg_ram #(
    .DEPTH (PRG_RAM_DEPTH)
  ) u_prg_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ram_ctrl),
    .addr_i  (ram_addr),
    .rdata_o (ram_rdata),
    .busy_o  (ram_busy)
  );

  // Output stage control. An entry marked pending takes its read data from the
  // RAM output, which holds that entry's byte during the cycle after its request;
  // at the next edge the byte is copied into the entry itself.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q     <= 1'b0;
      skid_v_q    <= 1'b0;
      out_pend_q  <= 1'b0;
      skid_pend_q <= 1'b0;
    end else if (!out_v_q || rsp_fire) begin
      out_v_q     <= skid_v_q || in_fire;
      out_pend_q  <= !skid_v_q && in_fire && rsp_is_read;
      skid_v_q    <= 1'b0;
      skid_pend_q <= 1'b0;
    end else begin
      out_pend_q <= 1'b0;
      if (in_fire) begin
        skid_v_q    <= 1'b1;
        skid_pend_q <= rsp_is_read;
      end else begin
        skid_pend_q <= 1'b0;
      end
    end
  end

  // Each entry as it stands this cycle, with a pending byte merged in.
  always_comb begin
    out_fill  = out_q;
    skid_fill = skid_q;
    if (out_pend_q) begin
      out_fill.read_data = ram_rdata;
    end
    if (skid_pend_q) begin
      skid_fill.read_data = ram_rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || rsp_fire) begin
      if (skid_v_q) begin
        out_q <= skid_fill;
      end else if (in_fire) begin
        out_q <= rsp_new;
      end
    end else begin
      out_q <= out_fill;
      if (in_fire) begin
        skid_q <= rsp_new;
      end else begin
        skid_q <= skid_fill;
      end
    end
  end

  assign rsp_o.payload = out_fill;
  assign rsp_o.valid   = out_v_q;

  // The skid register only fills behind a held output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_v_q |-> out_v_q)
    else $error("skid entry without an output entry");

  // Only PRG RAM reads wait on the RAM output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_v_q && out_pend_q) |-> (out_q.target == TGT_PRG_RAM))
    else $error("pending read data on a non-RAM response");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (skid_v_q && skid_pend_q) |-> (skid_q.target == TGT_PRG_RAM))
    else $error("pending read data on a non-RAM skid entry");

  // No request is taken while the RAM is being zeroed.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_busy |-> !in_fire)
    else $error("request taken during the RAM clearing pass");

  // A write to the IRQ disable register sets irq_off_q at the edge that takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_fire && req.opcode == OP_CPU_WRITE && req.address[15:13] == 3'b111
       && !req.address[0]) |=> irq_off_q)
    else $error("IRQ disable write not applied");

endmodule

// ----- rtl/core/bsm_prg_ram.sv -----
// ----------------------------------------------------------------------------
// Bank switch mapper PRG RAM
// Single-port byte RAM with registered read data and a zeroing pass after reset.
// ----------------------------------------------------------------------------
module bsm_prg_ram #(
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bsm_pkg::ram_ctrl_t       ctrl_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  output logic [7:0]               rdata_o,
  output logic                     busy_o
);
  import bsm_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;
  logic          busy_q;
  logic [AW-1:0] clr_addr_q;

  // The zeroing pass writes one entry per cycle, starting from entry zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else if (busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == LastAddr) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (ctrl_i.en && ctrl_i.we) begin
      mem[addr_i] <= ctrl_i.wdata;
    end
    if (!busy_q && ctrl_i.en && !ctrl_i.we) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

// ----- sim/bank_switch_mapper_irq_counter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Bank switch mapper testbench
// Drives CPU, PPU and A12 bus events into the mapper in random bursts, works
// out the expected mapping of every accepted request and checks each response.
// ----------------------------------------------------------------------------
module bank_switch_mapper_irq_counter_unit_tb;

  import bsm_pkg::*;

  // The PRG RAM depth matches the default of the block.
  localparam int RamDepth      = 8192;
  localparam int PhaseItems    = 100;
  localparam int NumPhases     = 7;
  // No request is accepted during the clearing pass after reset, which zeroes
  // RamDepth entries, so the watchdog allows several times RamDepth before giving up.
  localparam int WatchdogLimit = 40000;
  localparam int SettleCycles  = 20;

  // PRG ROM sizes and four-screen settings used by the random phases. The
  // final phase picks both at random.
  localparam int PrgBanksSeq [NumPhases] = '{1, 63, 0, 32, 17, 2, 0};
  localparam int FourSeq     [NumPhases] = '{1, 0, 1, 0, 1, 0, 0};

  typedef struct {
    req_t req;
    bit   hold;
  } bus_event_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgIdxW-1:0]    cfg_index_i;
  logic [CfgDataW-1:0]   cfg_wdata_i;

  bsm_stream_if #(.payload_t(req_t)) req_ch ();
  bsm_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  bank_switch_mapper_irq_counter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Mapper state as the testbench sees it. It starts from the reset values and
  // is updated only by accepted requests and, for the configuration, by write_cfg.
  // --------------------------------------------------------------------------
  logic [7:0]    bank_r [8] = '{default: 8'd0};
  logic [2:0]    sel_r         = 3'd0;
  logic          prg_swap_r    = 1'b0;
  logic          chr_inv_r     = 1'b0;
  mirror_e       mirror_r      = MIRROR_VERT;
  logic [7:0]    irq_latch_r   = 8'd0;
  logic [7:0]    irq_count_r   = 8'd0;
  logic          irq_off_r     = 1'b1;
  logic [7:0]    prg_ram_r [RamDepth];
  logic [5:0]    prg_banks_r   = PRG_BANKS_RESET;
  logic          four_screen_r = 1'b0;

  bus_event_t    bus_event_q [$];
  rsp_t          expected_rsp_q [$];
  int            mismatches = 0;
  int            in_flight = 0;
  int            idle_cycles = 0;
  bit            hold_next = 1'b0;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // PRG ROM offset of a CPU read at 0x8000 and above. The fixed banks follow
  // the configured ROM size, and every sum wraps at the 19-bit address width,
  // so a size of zero lands the fixed banks at the top of the space.
  function automatic logic [18:0] prg_rom_offset(logic [15:0] a);
    logic [18:0] fixed_lo;
    logic [18:0] r6_base;
    logic [18:0] r7_base;
    logic [18:0] base;
    fixed_lo = (19'(prg_banks_r) - 19'd1) * 19'h04000;
    r6_base  = {bank_r[6][5:0], 13'd0};
    r7_base  = {bank_r[7][5:0], 13'd0};
    case (a[14:13])
      2'b00: base = prg_swap_r ? fixed_lo : r6_base;
      2'b01: base = r7_base;
      2'b10: base = prg_swap_r ? r6_base : fixed_lo;
      default: base = fixed_lo + 19'h02000;
    endcase
    return base + 19'(a[12:0]);
  endfunction

  // CHR ROM offset of a pattern table access. The inversion bit swaps the two
  // 4 KiB halves; R0 and R1 cover 2 KiB each with their low bit ignored.
  function automatic logic [18:0] chr_rom_offset(logic [12:0] p);
    logic [12:0] t;
    t = p ^ {chr_inv_r, 12'd0};
    if (!t[12]) begin
      return 19'({bank_r[t[11]][7:1], t[10:0]});
    end
    return 19'({bank_r[3'd2 + 3'(t[11:10])], t[9:0]});
  endfunction

  // Mapper register write: the window comes from address bits 14:13 and
  // bit 0 picks the even or odd register of the pair.
  function automatic void write_mapper_reg(logic [15:0] a, logic [7:0] d);
    case (a[14:13])
      REG_BANK: begin
        if (!a[0]) begin
          sel_r      = d[2:0];
          prg_swap_r = d[6];
          chr_inv_r  = d[7];
        end else begin
          bank_r[sel_r] = d;
        end
      end
      REG_MIRROR: begin
        // The odd register would be RAM protect, which has no effect here.
        if (!a[0]) begin
          mirror_r = four_screen_r ? MIRROR_FOUR : mirror_e'({1'b0, d[0]});
        end
      end
      REG_IRQ_LATCH: begin
        if (!a[0]) begin
          irq_latch_r = d;
        end else begin
          irq_count_r = 8'd0;
        end
      end
      default: begin
        irq_off_r = !a[0];
      end
    endcase
  endfunction

  // Works out the response to one accepted bus event and applies its effect
  // on the mapper state.
  function automatic rsp_t map_bus_event(req_t r);
    rsp_t        o;
    logic [13:0] ppu;
    o = '0;
    case (r.opcode)
      OP_CPU_WRITE, OP_CPU_READ: begin
        if (r.address[15:13] == PRG_RAM_WINDOW) begin
          o.target         = TGT_PRG_RAM;
          o.mapped_address = 19'(r.address[12:0]);
          if (r.opcode == OP_CPU_WRITE) begin
            prg_ram_r[r.address[12:0]] = r.write_data;
          end else begin
            o.read_data = prg_ram_r[r.address[12:0]];
          end
        end else if (r.address[15]) begin
          if (r.opcode == OP_CPU_WRITE) begin
            write_mapper_reg(r.address, r.write_data);
          end else begin
            o.target         = TGT_PRG_ROM;
            o.mapped_address = prg_rom_offset(r.address);
          end
        end
        // CPU accesses below the RAM window are not decoded at all.
      end
      OP_PPU_WRITE, OP_PPU_READ: begin
        ppu = r.address[13:0];
        if (!ppu[13]) begin
          o.target         = TGT_CHR_ROM;
          o.mapped_address = chr_rom_offset(ppu[12:0]);
        end else begin
          o.target         = TGT_NAMETABLE;
          o.mapped_address = 19'(ppu);
        end
      end
      OP_A12_RISE: begin
        // An empty counter reloads from the latch, otherwise it counts down;
        // the interrupt fires whenever it ends up at zero while enabled.
        if (irq_count_r == 8'd0) begin
          irq_count_r = irq_latch_r;
        end else begin
          irq_count_r = irq_count_r - 8'd1;
        end
        o.irq_request = (irq_count_r == 8'd0) && !irq_off_r;
      end
      default: ;
    endcase
    o.mirror_mode = four_screen_r ? MIRROR_FOUR : mirror_r;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. Requests go out in bursts of random length separated by
  // random gaps. An event marked as held is not presented until every earlier
  // request has had its response, which empties the block completely.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else begin
      // The outstanding count is kept here from both handshakes, so the hold
      // decision does not depend on the order of the clocked blocks.
      if (req_ch.valid && req_ch.ready) begin
        in_flight++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        in_flight--;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (bus_event_q.size() != 0 &&
                     (!bus_event_q[0].hold || in_flight == 0)) begin
          req_ch.payload <= bus_event_q[0].req;
          req_ch.valid   <= 1'b1;
          void'(bus_event_q.pop_front());
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and response sink. Prediction happens here on every accepted
  // request, after any response of the same edge has been checked, so a
  // response can never be matched against a request taken at the same edge.
  // The sink stalls on a pattern chosen by the top two bits of a free-running
  // counter: always ready, random stalls, a short regular stall and long regular stalls.
  // --------------------------------------------------------------------------
  logic [8:0] sink_cycle = '0;

  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.payload;
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("response with no request waiting", got.target, 0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.target !== want.target) begin
            report_mismatch("target", got.target, want.target);
          end
          if (got.mapped_address !== want.mapped_address) begin
            report_mismatch("mapped_address", got.mapped_address, want.mapped_address);
          end
          if (got.read_data !== want.read_data) begin
            report_mismatch("read_data", got.read_data, want.read_data);
          end
          if (got.irq_request !== want.irq_request) begin
            report_mismatch("irq_request", got.irq_request, want.irq_request);
          end
          if (got.mirror_mode !== want.mirror_mode) begin
            report_mismatch("mirror_mode", got.mirror_mode, want.mirror_mode);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        expected_rsp_q.push_back(map_bus_event(req_ch.payload));
      end
      sink_cycle <= sink_cycle + 9'd1;
      case (sink_cycle[8:7])
        2'd0: rsp_ch.ready <= 1'b1;
        2'd1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        2'd2: rsp_ch.ready <= (sink_cycle[2:0] > 3'd1);
        default: rsp_ch.ready <= sink_cycle[4];
      endcase
    end
  end

  // The watchdog ends the run after too long without any handshake.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic queue_event(opcode_e op, logic [15:0] a, logic [7:0] d);
    bus_event_t ev;
    ev.req.opcode     = op;
    ev.req.address    = a;
    ev.req.write_data = d;
    ev.hold           = hold_next;
    hold_next         = 1'b0;
    bus_event_q.push_back(ev);
  endtask

  // Returns at a falling edge once no request is pending, none is on the
  // channel and every response has been checked.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (bus_event_q.size() != 0 || req_ch.valid || expected_rsp_q.size() != 0);
  endtask

  // Configuration writes are only issued while the block is idle, so the
  // predictor can take the new value straight away.
  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_PRG_BANKS) begin
      prg_banks_r = value;
    end else begin
      four_screen_r = value[0];
    end
  endtask

  // Directed requests from the reset state: the corners of the PRG windows,
  // the RAM window edges, undecoded CPU accesses, bank inversion, PPU address
  // wrap, mirroring, one full interrupt cycle and an unknown event kind.
  task automatic queue_directed();
    queue_event(OP_CPU_READ,  16'h8000, 8'h00);
    queue_event(OP_CPU_READ,  16'hFFFF, 8'h00);
    queue_event(OP_CPU_WRITE, 16'h6000, 8'hFF);
    queue_event(OP_CPU_WRITE, 16'h7FFF, 8'h5A);
    queue_event(OP_CPU_READ,  16'h7FFF, 8'h00);
    queue_event(OP_CPU_READ,  16'h6001, 8'h00);
    queue_event(OP_CPU_WRITE, 16'h5FFF, 8'h12);
    queue_event(OP_CPU_READ,  16'h0000, 8'hFF);
    queue_event(OP_CPU_WRITE, 16'h8000, 8'hC7);
    queue_event(OP_CPU_WRITE, 16'h8001, 8'hFF);
    queue_event(OP_CPU_READ,  16'hA000, 8'h00);
    queue_event(OP_CPU_READ,  16'hC000, 8'h00);
    queue_event(OP_PPU_READ,  16'h0000, 8'h00);
    queue_event(OP_PPU_WRITE, 16'h3FFF, 8'hAA);
    queue_event(OP_PPU_READ,  16'hFFFF, 8'h00);
    queue_event(OP_CPU_WRITE, 16'hA000, 8'h01);
    queue_event(OP_CPU_WRITE, 16'hA001, 8'h00);
    queue_event(OP_CPU_WRITE, 16'hC000, 8'h01);
    queue_event(OP_CPU_WRITE, 16'hC001, 8'h00);
    queue_event(OP_CPU_WRITE, 16'hE001, 8'h00);
    queue_event(OP_A12_RISE,  16'h1000, 8'h00);
    queue_event(OP_A12_RISE,  16'h1000, 8'h00);
    queue_event(OP_CPU_WRITE, 16'hE000, 8'h00);
    queue_event(OP_A12_RISE,  16'h1000, 8'h00);
    queue_event(opcode_e'(3'd7), 16'hFFFF, 8'hFF);
  endtask

  // Random requests for one phase. Most are well-formed mapper traffic: bank
  // programming pairs, PRG RAM write and read-back, PRG reads, pattern and
  // nametable fetches and scanline sequences that set the latch, mostly enable the
  // interrupt and clock A12 between PPU fetches. The rest is raw noise over
  // every event kind and address. One request half way through is held until
  // the block has drained.
  task automatic queue_random(int count);
    int          made;
    int          kind;
    int          lines;
    bit          held;
    logic [15:0] a;
    made = 0;
    held = 1'b0;
    while (made < count) begin
      if (!held && made >= count / 2) begin
        hold_next = 1'b1;
        held      = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        a = {3'b100, 13'($urandom)};
        queue_event(OP_CPU_WRITE, {a[15:1], 1'b0}, 8'($urandom));
        queue_event(OP_CPU_WRITE, {a[15:1], 1'b1}, 8'($urandom));
        made += 2;
      end else if (kind < 28) begin
        a = {1'b1, 2'($urandom_range(1, 3)), 13'($urandom)};
        queue_event(OP_CPU_WRITE, a, 8'($urandom));
        made++;
      end else if (kind < 43) begin
        queue_event(OP_CPU_READ, {1'b1, 15'($urandom)}, 8'($urandom));
        made++;
      end else if (kind < 55) begin
        a = {PRG_RAM_WINDOW, 13'($urandom)};
        queue_event(OP_CPU_WRITE, a, 8'($urandom));
        queue_event(OP_CPU_READ, a, 8'($urandom));
        queue_event(OP_CPU_READ, {PRG_RAM_WINDOW, 13'($urandom)}, 8'($urandom));
        made += 3;
      end else if (kind < 70) begin
        queue_event($urandom_range(0, 1) ? OP_PPU_READ : OP_PPU_WRITE,
                    16'($urandom), 8'($urandom));
        made++;
      end else if (kind < 90) begin
        queue_event(OP_CPU_WRITE, {3'b110, 13'($urandom)} & 16'hFFFE,
                    8'($urandom_range(0, 6)));
        queue_event(OP_CPU_WRITE, {3'b110, 13'($urandom)} | 16'h0001, 8'($urandom));
        queue_event(OP_CPU_WRITE, {3'b111, 12'($urandom), ($urandom_range(0, 3) != 0)},
                    8'($urandom));
        made += 3;
        lines = $urandom_range(1, 10);
        repeat (lines) begin
          queue_event(OP_A12_RISE, 16'($urandom), 8'($urandom));
          queue_event(OP_PPU_READ, {3'b000, 13'($urandom)}, 8'($urandom));
          made += 2;
        end
      end else begin
        // Noise does not count towards the phase length.
        queue_event(opcode_e'($urandom_range(0, 7)), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence: reset, the directed requests with the reset configuration,
  // then one random phase per configuration, each written while idle. The
  // phases cover the smallest and largest legal PRG sizes, sizes of zero and
  // above the legal range, and four-screen on and off.
  // --------------------------------------------------------------------------
  initial begin
    logic [5:0] banks;
    logic       four;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_PRG_BANKS;
    cfg_wdata_i    = '0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    foreach (prg_ram_r[i]) begin
      prg_ram_r[i] = 8'd0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    queue_directed();
    wait_idle();
    for (int p = 0; p < NumPhases; p++) begin
      if (p == NumPhases - 1) begin
        banks = 6'($urandom_range(0, 63));
        four  = 1'($urandom_range(0, 1));
      end else begin
        banks = 6'(PrgBanksSeq[p]);
        four  = 1'(FourSeq[p]);
      end
      write_cfg(CFG_PRG_BANKS, banks);
      write_cfg(CFG_FOUR_SCREEN, {5'd0, four});
      @(negedge clk_i);
      queue_random(PhaseItems);
      wait_idle();
    end
    // Give a stray late response the chance to show up before the verdict.
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bsm_pkg.sv
rtl/core/bsm_stream_if.sv
rtl/core/bsm_prg_ram.sv
rtl/core/bank_switch_mapper_irq_counter_unit.sv
sim/bank_switch_mapper_irq_counter_unit_tb.sv
